// ----- rtl/flna_pkg.sv -----
// Shared types and constants for the free-list node allocator.
// No dependencies; imported by every module of the allocator.
`timescale 1ns / 1ps

package flna_pkg;

  localparam int unsigned NODE_W       = 10;  // node_index and granted_node width
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CFG_W        = 11;  // nodes_per_block width
  localparam logic [CFG_W-1:0] NPB_RESET = 11'd64;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_FREE  = 2'd2
  } flna_status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } flna_mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_GROW,
    S_DONE
  } flna_state_t;

endpackage

// ----- rtl/flna_link_mem.sv -----
// Next-link memory of the allocator: one write port, one read port,
// registered read data. Depends on flna_pkg.
`timescale 1ns / 1ps

module flna_link_mem
  import flna_pkg::*;
#(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [(1 << AW)];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/free_list_node_allocator.sv -----
// Top level of the free-list node allocator: control sequencer, head and
// build-count registers, output register. Depends on flna_pkg, flna_link_mem.
`timescale 1ns / 1ps

// Fixed-size node allocator with a LIFO free list held as a head register
// and a next-link memory of MAX_NODES entries. Each transaction gives one
// result. A release, a refused release and an exhausted allocate finish in
// the accept state; an allocate from a non-empty list finishes in S_READ,
// as the link of the head is fetched through the memory's registered read
// port. When the list is empty an allocate first chains a fresh block of
// nodes_per_block nodes (a setting of 0 counts as 1), one link write per
// cycle in S_GROW, and pops the first of them with the last write. The input
// is stalled until the current transaction's result has entered the output
// register, where it waits while the next transaction is taken. Write
// nodes_per_block only while the block is idle.
module free_list_node_allocator
  import flna_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [NODE_W-1:0]   in_node_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [NODE_W-1:0]   out_granted_node,
  output logic [STATUS_W-1:0] out_status
);

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned NW = $clog2(MAX_NODES + 1);
  localparam int unsigned SW = ((NW > CFG_W) ? NW : CFG_W) + 1;
  localparam int unsigned CW = (NW > NODE_W) ? NW : NODE_W;
  localparam logic [NW-1:0] EMPTY = NW'(MAX_NODES);
  localparam logic [SW-1:0] MAX_S = SW'(MAX_NODES);

  flna_state_t state_r, state_nxt;
  logic [CFG_W-1:0]    npb_r;
  logic [NW-1:0]       head_r, head_nxt;
  logic [NW-1:0]       built_r, built_nxt;
  logic [NW-1:0]       cnt_r, cnt_nxt;
  logic [NW-1:0]       res_granted_r, res_granted_nxt;
  flna_status_t        res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]   out_granted_r, out_granted_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [NW-1:0] mem_wr_data, mem_rd_data;

  logic          in_acc, out_free;
  logic          fin;
  logic [NW-1:0] fin_granted;
  flna_status_t  fin_status;
  logic [SW-1:0] n_eff, grow_pos, grow_next;
  logic          exhausted, bad_free, grow_last;

  flna_link_mem #(
    .AW (AW),
    .DW (NW)
  ) u_link_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  assign n_eff     = (npb_r == '0) ? SW'(1) : SW'(npb_r);
  assign exhausted = (SW'(built_r) + n_eff) > MAX_S;
  assign bad_free  = CW'(in_node_index) >= CW'(built_r);
  assign grow_pos  = SW'(built_r) + SW'(cnt_r);
  assign grow_next = SW'(cnt_r) + SW'(1);
  assign grow_last = (grow_next == n_eff);

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    built_nxt       = built_r;
    cnt_nxt         = cnt_r;
    res_granted_nxt = res_granted_r;
    res_status_nxt  = res_status_r;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = AW'(in_node_index);
    mem_wr_data     = head_r;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = head_r[AW-1:0];
    fin             = 1'b0;
    fin_granted     = '0;
    fin_status      = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_ALLOC) begin
            if (head_r != EMPTY) begin
              mem_rd_en = 1'b1;
              state_nxt = S_READ;
            end else if (exhausted) begin
              fin        = 1'b1;
              fin_status = ST_EXHAUSTED;
            end else begin
              cnt_nxt   = '0;
              state_nxt = S_GROW;
            end
          end else begin
            if (bad_free) begin
              fin        = 1'b1;
              fin_status = ST_BAD_FREE;
            end else begin
              // push: old head becomes the released node's link
              mem_wr_en = 1'b1;
              head_nxt  = NW'(in_node_index);
              fin       = 1'b1;
            end
          end
        end
      end
      S_READ: begin
        fin         = 1'b1;
        fin_granted = head_r;
        head_nxt    = mem_rd_data;
      end
      S_GROW: begin
        // chain the fresh block in ascending order, one link per cycle
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(grow_pos);
        mem_wr_data = grow_last ? EMPTY : NW'(grow_pos + SW'(1));
        cnt_nxt     = cnt_r + NW'(1);
        if (grow_last) begin
          // pop the first node of the new block straight away
          fin         = 1'b1;
          fin_granted = built_r;
          head_nxt    = (n_eff > SW'(1)) ? (built_r + NW'(1)) : EMPTY;
          built_nxt   = NW'(SW'(built_r) + n_eff);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      res_granted_nxt = fin_granted;
      res_status_nxt  = fin_status;
      state_nxt       = out_free ? S_IDLE : S_DONE;
    end
  end

  always_comb begin
    out_valid_nxt   = out_valid_r && out_stall;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    if (fin && out_free) begin
      out_valid_nxt   = 1'b1;
      out_granted_nxt = NODE_W'(fin_granted);
      out_status_nxt  = fin_status;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_nxt   = 1'b1;
      out_granted_nxt = NODE_W'(res_granted_r);
      out_status_nxt  = res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= EMPTY;
      built_r     <= '0;
      npb_r       <= NPB_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        npb_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    res_granted_r <= res_granted_nxt;
    res_status_r  <= res_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_node = out_granted_r;
  assign out_status       = out_status_r;

`ifndef SYNTHESIS
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == EMPTY) || (head_r < built_r))
    else $error("free-list head outside built nodes");

  a_built_range: assert property (@(posedge clk) disable iff (!rst_n)
    built_r <= NW'(MAX_NODES))
    else $error("build count beyond pool size");

  a_free_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == MODE_FREE && !bad_free)
      |=> (head_r == NW'($past(in_node_index))))
    else $error("released node did not become head");

  a_grow_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GROW) |-> (SW'(cnt_r) < n_eff))
    else $error("block build ran past block size");
`endif

endmodule

// ----- tb/flna_grant_checker.sv -----
// Grant checker for the free-list node allocator: predicts each grant from the
// accepted transactions and compares it with the result channel. Uses flna_pkg.
`timescale 1ns / 1ps

module flna_grant_checker
  import flna_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_mode,
  input  logic [NODE_W-1:0]   in_node_index,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [NODE_W-1:0]   out_granted_node,
  input  logic [STATUS_W-1:0] out_status,
  output int                  pending,
  output logic [CFG_W-1:0]    pool_built,
  output int                  fail_count
);

  localparam logic [CFG_W-1:0] LIST_END = CFG_W'(MAX_NODES);
  localparam int unsigned      LW       = $clog2(MAX_NODES);

  typedef struct packed {
    logic [NODE_W-1:0] node;
    flna_status_t      status;
  } grant_t;

  logic [CFG_W-1:0] link_mem [MAX_NODES];
  logic [CFG_W-1:0] head_q;
  logic [CFG_W-1:0] built_q;
  logic [CFG_W-1:0] blk_size_q;
  grant_t           grant_q [$];
  int               mismatches = 0;

  assign pool_built = built_q;
  assign fail_count = mismatches;

  // Work out the grant for one transaction and advance the predicted list.
  task predict_grant(input flna_mode_t mode, input logic [NODE_W-1:0] idx);
    grant_t           exp_g;
    logic [CFG_W-1:0] n;
    logic [CFG_W-1:0] taken;
    logic [CFG_W-1:0] after;
    bit               grew;
    int               k;
    exp_g.node   = '0;
    exp_g.status = ST_OK;
    grew         = 1'b0;
    taken        = head_q;
    after        = LIST_END;
    n            = '0;
    if (mode == MODE_FREE) begin
      if (CFG_W'(idx) >= built_q) begin
        exp_g.status = ST_BAD_FREE;
      end else begin
        link_mem[LW'(idx)] <= head_q;
        head_q             <= CFG_W'(idx);
      end
    end else begin
      if (head_q == LIST_END) begin
        n = (blk_size_q == '0) ? CFG_W'(1) : blk_size_q;
        if (int'(built_q) + int'(n) > int'(MAX_NODES)) begin
          exp_g.status = ST_EXHAUSTED;
        end else begin
          // chain the fresh block in ascending order, last one ends the list
          for (k = 0; k < int'(n); k++) begin
            link_mem[LW'(int'(built_q) + k)] <= (k + 1 < int'(n)) ?
                                           CFG_W'(int'(built_q) + k + 1) : LIST_END;
          end
          built_q <= built_q + n;
          taken    = built_q;
          grew     = 1'b1;
        end
      end
      if (exp_g.status == ST_OK) begin
        if (grew) begin
          after = (n > 1) ? built_q + 1'b1 : LIST_END;
        end else begin
          after = link_mem[LW'(head_q)];
        end
        exp_g.node = taken[NODE_W-1:0];
        head_q    <= after;
      end
    end
    grant_q.push_back(exp_g);
  endtask

  task check_grant();
    grant_t exp_g;
    if (grant_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result: node %0d status %0d", out_granted_node, out_status);
      end
    end else begin
      exp_g = grant_q.pop_front();
      if (out_granted_node !== exp_g.node || out_status !== exp_g.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("grant mismatch: expected node %0d status %0d, got node %0d status %0d",
                   exp_g.node, exp_g.status, out_granted_node, out_status);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head_q     <= LIST_END;
      built_q    <= '0;
      blk_size_q <= NPB_RESET;
      grant_q.delete();
      pending    <= 0;
    end else begin
      if (cfg_wr_en) begin
        blk_size_q <= cfg_wr_data;
      end
      // the result always belongs to an older transaction, so compare first
      if (out_valid && !out_stall) begin
        check_grant();
      end
      if (in_valid && !in_stall) begin
        predict_grant(flna_mode_t'(in_mode), in_node_index);
      end
      pending <= grant_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the allocator testbench: clock, reset, directed and random stimulus,
// watchdog and verdict. Depends on flna_pkg, flna_grant_checker and the block.
`timescale 1ns / 1ps

module tb_top;
  import flna_pkg::*;

  localparam int unsigned POOL_NODES     = 1024;
  localparam int unsigned ITEM_TARGET    = 1650;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                cfg_wr_en     = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data   = '0;
  logic                in_valid      = 1'b0;
  logic                in_mode       = 1'b0;
  logic [NODE_W-1:0]   in_node_index = '0;
  logic                out_stall     = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [NODE_W-1:0]   out_granted_node;
  logic [STATUS_W-1:0] out_status;

  int                  pending;
  int                  fail_count;
  logic [CFG_W-1:0]    pool_built;

  logic [NODE_W-1:0]   held_nodes [$];
  flna_mode_t          mode_fifo [$];
  logic [CFG_W-1:0]    cur_blk      = NPB_RESET;
  bit                  quiet        = 1'b0;
  int unsigned         items_sent   = 0;
  int unsigned         stall_run    = 0;
  int unsigned         stuck_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  free_list_node_allocator #(
    .MAX_NODES (POOL_NODES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_node_index    (in_node_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_node (out_granted_node),
    .out_status       (out_status)
  );

  flna_grant_checker #(
    .MAX_NODES (POOL_NODES)
  ) i_grant_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_node_index    (in_node_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_node (out_granted_node),
    .out_status       (out_status),
    .pending          (pending),
    .pool_built       (pool_built),
    .fail_count       (fail_count)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_item(input flna_mode_t m, input logic [NODE_W-1:0] idx);
    int unsigned gap;
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_node_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every outstanding grant has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_W-1:0] blk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= blk;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_blk      = blk;
  endtask

  task automatic alloc_item();
    push_item(MODE_ALLOC, NODE_W'($urandom_range(0, POOL_NODES - 1)));
  endtask

  task automatic random_item(input int unsigned alloc_pct);
    int unsigned r;
    int unsigned lo;
    int unsigned pick;
    logic [NODE_W-1:0] nd;
    r = $urandom_range(0, 99);
    // the transaction accepted at this edge may still grow the pool
    lo = int'(pool_built) + ((cur_blk == '0) ? 1 :
                             (int'(cur_blk) > POOL_NODES ? 0 : int'(cur_blk)));
    if (r < 8 && lo < POOL_NODES) begin
      push_item(MODE_FREE, NODE_W'($urandom_range(lo, POOL_NODES - 1)));
    end else if (r < alloc_pct || held_nodes.size() == 0) begin
      alloc_item();
    end else begin
      pick = $urandom_range(0, held_nodes.size() - 1);
      nd   = held_nodes[pick];
      held_nodes.delete(pick);
      push_item(MODE_FREE, nd);
    end
  endtask

  // Track nodes handed out so that releases mostly return what is held.
  always @(posedge clk) begin
    flna_mode_t m;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        m = mode_fifo.pop_front();
        if (m == MODE_ALLOC && out_status == ST_OK) begin
          held_nodes.push_back(out_granted_node);
        end
      end
      if (in_valid && !in_stall) begin
        mode_fifo.push_back(flna_mode_t'(in_mode));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_run <= idle_len();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int unsigned       phase_len;
    int unsigned       alloc_pct;
    int unsigned       r;
    logic [CFG_W-1:0]  blk;
    logic [NODE_W-1:0] nd;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset block size: first allocate builds nodes 0..63
    push_item(MODE_ALLOC, '1);
    push_item(MODE_ALLOC, '0);
    push_item(MODE_FREE, NODE_W'(64));  // one past the last built node
    push_item(MODE_FREE, '1);
    wait_idle();
    push_item(MODE_FREE, held_nodes.pop_back());
    push_item(MODE_FREE, held_nodes.pop_back());
    push_item(MODE_ALLOC, NODE_W'(10'h155));
    push_item(MODE_ALLOC, NODE_W'(10'h2AA));
    wait_idle();

    // oversized block: drain the list, then every allocate is exhausted
    write_cfg('1);
    repeat (64) alloc_item();
    wait_idle();
    push_item(MODE_FREE, held_nodes.pop_back());
    alloc_item();
    alloc_item();
    wait_idle();

    // zero block size behaves as one
    write_cfg('0);
    alloc_item();
    alloc_item();
    wait_idle();
    push_item(MODE_FREE, held_nodes.pop_back());
    alloc_item();
    wait_idle();

    write_cfg(CFG_W'(1));
    alloc_item();
    wait_idle();
    push_item(MODE_FREE, held_nodes.pop_back());
    alloc_item();
    wait_idle();

    // largest legal block no longer fits once anything is built
    write_cfg(CFG_W'(POOL_NODES));
    alloc_item();
    alloc_item();

    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      r = $urandom_range(0, 99);
      if (r < 40) begin
        blk = CFG_W'($urandom_range(1, 8));
      end else if (r < 65) begin
        blk = CFG_W'($urandom_range(9, 64));
      end else if (r < 75) begin
        blk = '0;
      end else if (r < 85) begin
        blk = CFG_W'($urandom_range(900, 2047));
      end else if (pool_built >= CFG_W'(POOL_NODES / 2) && pool_built < CFG_W'(POOL_NODES)) begin
        blk = CFG_W'(POOL_NODES) - pool_built;  // exact fit up to the last node
      end else begin
        blk = CFG_W'($urandom_range(1, 4));
      end
      write_cfg(blk);
      case ($urandom_range(0, 3))
        0:       alloc_pct = 20;
        1:       alloc_pct = 50;
        2:       alloc_pct = 70;
        default: alloc_pct = 90;
      endcase
      quiet    <= ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(20, 150);
      repeat (phase_len) random_item(alloc_pct);
    end

    // double release goes undetected; kept last as it loops the list
    wait_idle();
    quiet <= 1'b0;
    write_cfg(CFG_W'(1));
    if (held_nodes.size() == 0) begin
      alloc_item();
      wait_idle();
    end
    if (held_nodes.size() != 0) begin
      nd = held_nodes.pop_back();
      push_item(MODE_FREE, nd);
      push_item(MODE_FREE, nd);
      repeat (3) alloc_item();
    end
    wait_idle();
    repeat (16) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
